// ===== hdl/srt_pkg.sv =====
// Shared types and constants for the sorted record table.
// Holds the command and result beat formats, the record layout and the emit request.
// No dependencies.
`default_nettype none

package srt_pkg;

  localparam int FILL_W      = 7;
  localparam int MAX_RESULTS = 64;
  localparam int MATCH_W     = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] rec_key;
    logic [15:0] dest_code;
    logic [15:0] kind_code;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [15:0]       out_key;
    logic [15:0]       out_dest;
    logic [15:0]       out_kind;
    logic [FILL_W-1:0] fill_count;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] dest;
    logic [15:0] kind;
  } rec_t;

  // Request from the sequencer to the result stage.
  typedef struct packed {
    logic              push;      // hold this record, release the held one
    logic              close;     // emit the final beat of the item
    logic              use_pend;  // on close, prefer the held record if any
    status_e           status;
    rec_t              rec;
    logic [FILL_W-1:0] fill;
  } emit_req_t;

  function automatic res_t make_res(input status_e s, input rec_t r,
                                    input logic [FILL_W-1:0] f, input logic l);
    res_t res;
    res.status     = s;
    res.out_key    = r.key;
    res.out_dest   = r.dest;
    res.out_kind   = r.kind;
    res.fill_count = f;
    res.last       = l;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/srt_mem.sv =====
// Record memory of the sorted record table: one write port, one read port.
// Read data is registered. Depends on srt_pkg.
`default_nettype none

module srt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  srt_pkg::rec_t  wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output srt_pkg::rec_t  rdata_o
);
  import srt_pkg::*;

  rec_t ram_q [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= ram_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/srt_emit.sv =====
// Result stage of the sorted record table: holds one matched record back so
// that the final beat of an item can carry last. Depends on srt_pkg.
`default_nettype none

module srt_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srt_pkg::emit_req_t req_i,
  output logic               valid_o,
  output srt_pkg::res_t      res_o
);
  import srt_pkg::*;

  logic pend_v_q, pend_v_d;
  rec_t pend_q, pend_d;
  logic valid_q, valid_d;
  res_t res_q, res_d;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    if (req_i.push) begin
      pend_d   = req_i.rec;
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        valid_d = 1'b1;
        res_d   = make_res(ST_OK, pend_q, req_i.fill, 1'b0);
      end
    end else if (req_i.close) begin
      valid_d  = 1'b1;
      pend_v_d = 1'b0;
      if (req_i.use_pend && pend_v_q) begin
        res_d = make_res(ST_OK, pend_q, req_i.fill, 1'b1);
      end else begin
        res_d = make_res(req_i.status, req_i.rec, req_i.fill, 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== hdl/sorted_record_table.sv =====
// Top level of the sorted record table: command sequencer over the record memory.
// Depends on srt_pkg, srt_mem and srt_emit.
//
//   Channel   Ports                    Handshake
//   command   start, busy, item_i      beat taken when start is high and busy is low
//   result    res_valid_o, res_o       one-cycle strobe, receiver cannot stall
//
// An insert walks down from the top entry, moving each record whose key is not smaller
// up by one; delete, search and dump walk the whole table while busy is high.
// The walks are paced by the single memory read port, which delivers one record
// per cycle. A full insert, or a delete, search or dump on an empty table,
// answers without raising busy.
// The final result beat appears in the cycle busy drops, and a new command may be
// taken in that same cycle. Reset empties the table at once; no clearing pass.
`default_nettype none

module sorted_record_table #(
  parameter int CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  srt_pkg::item_t item_i,
  output logic           res_valid_o,
  output srt_pkg::res_t  res_o
);
  import srt_pkg::*;

  // Address width for the entries, count width so that the full count fits.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_SCAN
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;        // records held
  logic [CW-1:0]      idx_q, idx_d;        // next entry to read
  logic               rd_v_q, rd_v_d;      // read issued in the previous cycle
  logic [AW-1:0]      rd_idx_q, rd_idx_d;  // entry that read targets
  logic               found_q, found_d;    // delete has met its key
  logic [MATCH_W-1:0] nmatch_q, nmatch_d;  // search or dump results taken so far
  item_t              item_q, item_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_rdata;

  emit_req_t     req;
  rec_t          new_rec;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] cnt_p1;
  logic [CW-1:0] cnt_m1;
  logic          hit;

  // The fill count reported is the record count cut to its low seven bits.
  function automatic logic [FILL_W-1:0] fill_of(input logic [CW-1:0] c);
    logic [FILL_W+CW-1:0] w;
    w = {{FILL_W{1'b0}}, c};
    return w[FILL_W-1:0];
  endfunction

  assign new_rec = '{key: item_q.rec_key, dest: item_q.dest_code, kind: item_q.kind_code};
  assign idx_m1  = idx_q - 1'b1;
  assign cnt_p1  = cnt_q + 1'b1;
  assign cnt_m1  = cnt_q - 1'b1;

  // A dump takes every entry, a search only those whose destination matches.
  assign hit = (item_q.cmd == CMD_DUMP) || (mem_rdata.dest == item_q.dest_code);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    rd_v_d    = 1'b0;
    rd_idx_d  = rd_idx_q;
    found_d   = found_q;
    nmatch_d  = nmatch_q;
    item_d    = item_q;
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    req       = '0;
    req.status = ST_OK;
    req.fill  = fill_of(cnt_q);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d   = item_i;
          idx_d    = '0;
          found_d  = 1'b0;
          nmatch_d = '0;
          if (item_i.cmd == CMD_INSERT) begin
            if (cnt_q >= CW'(CAPACITY)) begin
              req.close  = 1'b1;
              req.status = ST_FULL;
            end else begin
              // Walk down from the top entry, moving each key not smaller than the new one up by one.
              idx_d   = cnt_q;
              state_d = S_INS;
            end
          end else if (cnt_q == '0) begin
            req.close  = 1'b1;
            req.status = ST_EMPTY;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_INS: begin
        if ((rd_v_q && (mem_rdata.key < item_q.rec_key)) || (!rd_v_q && (idx_q == '0))) begin
          // The slot is just above the last entry read, or the bottom of the table.
          mem_we     = 1'b1;
          mem_waddr  = rd_v_q ? AW'(rd_idx_q + 1'b1) : '0;
          mem_wdata  = new_rec;
          cnt_d      = cnt_p1;
          req.close  = 1'b1;
          req.status = ST_OK;
          req.rec    = new_rec;
          req.fill   = fill_of(cnt_p1);
          state_d    = S_IDLE;
        end else begin
          if (rd_v_q) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(rd_idx_q + 1'b1);
            mem_wdata = mem_rdata;
          end
          if (idx_q != '0) begin
            mem_re    = 1'b1;
            mem_raddr = idx_m1[AW-1:0];
            idx_d     = idx_m1;
            rd_v_d    = 1'b1;
            rd_idx_d  = idx_m1[AW-1:0];
          end
        end
      end

      S_SCAN: begin
        // Reads run ahead by one entry; writes only go to entries already read.
        if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          idx_d     = idx_q + 1'b1;
          rd_v_d    = 1'b1;
          rd_idx_d  = idx_q[AW-1:0];
        end
        if (rd_v_q) begin
          if (item_q.cmd == CMD_DELETE) begin
            if (!found_q && (mem_rdata.key == item_q.rec_key)) begin
              found_d  = 1'b1;
              req.push = 1'b1;
              req.rec  = mem_rdata;
            end else if (found_q) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(rd_idx_q - 1'b1);
              mem_wdata = mem_rdata;
            end
          end else if (hit && (nmatch_q < MATCH_W'(MAX_RESULTS))) begin
            req.push = 1'b1;
            req.rec  = mem_rdata;
            nmatch_d = nmatch_q + 1'b1;
          end
        end else if (idx_q == cnt_q) begin
          // Whole table seen: release the held record as the final beat, or miss.
          req.close    = 1'b1;
          req.use_pend = 1'b1;
          req.status   = ST_MISS;
          if (found_q) begin
            cnt_d    = cnt_m1;
            req.fill = fill_of(cnt_m1);
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      rd_v_q   <= 1'b0;
      rd_idx_q <= '0;
      found_q  <= 1'b0;
      nmatch_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      rd_v_q   <= rd_v_d;
      rd_idx_q <= rd_idx_d;
      found_q  <= found_d;
      nmatch_q <= nmatch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign busy = (state_q != S_IDLE);

  srt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  srt_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

// ===== hdl/srt_chk.sv =====
// Port-level checks for the sorted record table, bound to the top level.
// Depends on srt_pkg and sorted_record_table.
`default_nettype none

module srt_chk #(
  parameter int CAPACITY = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          res_valid_o,
  input srt_pkg::res_t res_o
);
  import srt_pkg::*;

  localparam logic [FILL_W-1:0] CapFill = FILL_W'(CAPACITY % 128);

  // A taken command either starts work or answers at once with its only beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || (res_valid_o && res_o.last))
    else $error("command neither started nor answered");

  // Finishing work always coincides with the final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.last)
    else $error("work ended without a final beat");

  // More beats follow only while the command is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy && (res_o.status == ST_OK))
    else $error("non-final beat outside a running command");

  // Error answers stand alone and carry no record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != ST_OK) |->
      res_o.last && (res_o.out_key == '0) && (res_o.out_dest == '0) && (res_o.out_kind == '0))
    else $error("error beat with record data or without last");

  // A full answer only happens at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == ST_FULL) |-> res_o.fill_count == CapFill)
    else $error("full reported below capacity");

endmodule

bind sorted_record_table srt_chk #(
  .CAPACITY (CAPACITY)
) u_srt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire
